FILE: rtl/ripemd160_hash_engine_macros.svh
// ----------------------------------------------------------------------------
// ripemd160_hash_engine_macros
// assertion macros for the ripemd-160 engine
// ----------------------------------------------------------------------------
`ifndef RIPEMD160_HASH_ENGINE_MACROS_SVH
`define RIPEMD160_HASH_ENGINE_MACROS_SVH
// assert that a implies b at the same edge
`define RMD_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// assert that a implies b at the next edge
`define RMD_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

FILE: rtl/rmd_pkg.sv
// ----------------------------------------------------------------------------
// rmd_pkg
// constants and round tables for the ripemd-160 engine
// ----------------------------------------------------------------------------
package rmd_pkg;
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hc3d2e1f0;

   function automatic logic [3:0] wl_f(input logic [6:0] j);
      logic [3:0] t [0:79];
      t = '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,
            4'd14,4'd15,
            4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,
            4'd11,4'd8,
            4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,
            4'd5,4'd12,
            4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,
            4'd6,4'd2,
            4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,
            4'd15,4'd13};
      return t[j];
   endfunction

   function automatic logic [3:0] wr_f(input logic [6:0] j);
      logic [3:0] t [0:79];
      t = '{4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,
            4'd3,4'd12,
            4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,
            4'd1,4'd2,
            4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,
            4'd4,4'd13,
            4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,
            4'd10,4'd14,
            4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,
            4'd9,4'd11};
      return t[j];
   endfunction

   function automatic logic [3:0] sl_f(input logic [6:0] j);
      logic [3:0] t [0:79];
      t = '{4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,
            4'd7,4'd9,4'd8,
            4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,
            4'd13,4'd12,
            4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,
            4'd7,4'd5,
            4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,
            4'd5,4'd12,
            4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,
            4'd5,4'd6};
      return t[j];
   endfunction

   function automatic logic [3:0] sr_f(input logic [6:0] j);
      logic [3:0] t [0:79];
      t = '{4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,
            4'd12,4'd6,
            4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,
            4'd13,4'd11,
            4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,
            4'd7,4'd5,
            4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,
            4'd15,4'd8,
            4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,
            4'd11,4'd11};
      return t[j];
   endfunction

   function automatic logic [31:0] kl_f(input logic [2:0] r);
      case (r)
         3'd0: return 32'h00000000;
         3'd1: return 32'h5a827999;
         3'd2: return 32'h6ed9eba1;
         3'd3: return 32'h8f1bbcdc;
         default: return 32'ha953fd4e;
      endcase
   endfunction

   function automatic logic [31:0] kr_f(input logic [2:0] r);
      case (r)
         3'd0: return 32'h50a28be6;
         3'd1: return 32'h5c4dd124;
         3'd2: return 32'h6d703ef3;
         3'd3: return 32'h7a6d76e9;
         default: return 32'h00000000;
      endcase
   endfunction

   function automatic logic [31:0] bool_f(input logic [2:0] r, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
      case (r)
         3'd0: return x ^ y ^ z;
         3'd1: return (x & y) | (~x & z);
         3'd2: return (x | ~y) ^ z;
         3'd3: return (x & z) | (y & ~z);
         default: return x ^ (y | ~z);
      endcase
   endfunction

   function automatic logic [31:0] rotl_f(input logic [31:0] x, input logic [3:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction
endpackage

FILE: rtl/rmd_if.sv
// ----------------------------------------------------------------------------
// rmd_req_if / rmd_rsp_if
// valid-ready channels for requests and digest words
// ----------------------------------------------------------------------------
interface rmd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   modport source (output valid, kind, data_byte, input ready);
   modport sink (input valid, kind, data_byte, output ready);
endinterface

interface rmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/ripemd160_hash_engine.sv
// ----------------------------------------------------------------------------
// ripemd160_hash_engine
// byte-fed ripemd-160 with one shared round unit
// ----------------------------------------------------------------------------
// A data request is taken while the engine is idle; the 64th byte of a block
// then starts the compression, which runs one step of both lines per cycle
// through all steps and then updates the chaining words. A finish request
// feeds the padding bytes through the same byte path, one per cycle (9 to 72
// bytes plus one or two compressions), then presents five digest words on
// the response channel, one per accepted response. The engine is not ready
// while it compresses, pads or emits.
module ripemd160_hash_engine (
   input logic clock,
   input logic reset,
   rmd_req_if.sink   req,
   rmd_rsp_if.source rsp
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PAD  = 5'b00010,
      ST_RND  = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] blk_ff [0:15];
   logic [31:0] h_ff [0:4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] ap_ff, bp_ff, cp_ff, dp_ff, ep_ff;
   logic [60:0] cnt_ff;
   logic [63:0] bits_ff;     // length latched at finish
   logic        pad_ff;      // finish in progress
   logic [3:0]  pidx_ff;     // length byte index while padding
   logic        plen_ff;     // emitting length bytes
   logic [6:0]  j_ff;
   logic [2:0]  oidx_ff;

   // byte feed: from request or padding generator
   logic       bvalid;
   logic [7:0] bval;
   logic [5:0] pos;
   assign pos = cnt_ff[5:0];

   always_comb begin
      bval = 8'h00;
      if (state_ff == ST_IDLE) bval = req.data_byte;
      else if (!pad_ff) bval = 8'h00;
      else if (plen_ff) bval = bits_ff[8*pidx_ff[2:0] +: 8];
      else if (pidx_ff == 4'd8) bval = 8'h80;   // first pad byte
      else bval = 8'h00;
   end
   assign bvalid = (state_ff == ST_IDLE && req.valid && !req.kind) ||
                   (state_ff == ST_PAD);

   assign req.ready = (state_ff == ST_IDLE);

   // round unit
   logic [2:0]  r;
   logic [31:0] tl, tr;
   assign r = (j_ff < 7'd16) ? 3'd0 : (j_ff < 7'd32) ? 3'd1 :
              (j_ff < 7'd48) ? 3'd2 : (j_ff < 7'd64) ? 3'd3 : 3'd4;
   assign tl = rmd_pkg::rotl_f(a_ff + rmd_pkg::bool_f(r, b_ff, c_ff, d_ff)
               + blk_ff[rmd_pkg::wl_f(j_ff)] + rmd_pkg::kl_f(r), rmd_pkg::sl_f(j_ff))
               + e_ff;
   assign tr = rmd_pkg::rotl_f(ap_ff + rmd_pkg::bool_f(3'd4 - r, bp_ff, cp_ff, dp_ff)
               + blk_ff[rmd_pkg::wr_f(j_ff)] + rmd_pkg::kr_f(r), rmd_pkg::sr_f(j_ff))
               + ep_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid) state_in = req.kind ? ST_PAD :
                                 (pos == 6'd63 ? ST_RND : ST_IDLE);
         ST_PAD:  if (pos == 6'd63) state_in = ST_RND;
         ST_RND:  if (j_ff == 7'd79) state_in = ST_FIN;
         ST_FIN:  state_in = !pad_ff ? ST_IDLE : (plen_ff && pidx_ff == 4'd8) ? ST_OUT
                             : ST_PAD;
         ST_OUT:  if (rsp.ready && oidx_ff == 3'd4) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pad_ff   <= 1'b0;
         j_ff     <= '0;
         oidx_ff  <= '0;
         h_ff     <= '{rmd_pkg::IV0, rmd_pkg::IV1, rmd_pkg::IV2, rmd_pkg::IV3, rmd_pkg::IV4};
      end else begin
         state_ff <= state_in;
         if (bvalid) begin
            // first byte of a word overwrites it
            if (pos[1:0] == 2'd0) blk_ff[pos[5:2]] <= {24'd0, bval};
            else blk_ff[pos[5:2]][8*pos[1:0] +: 8] <= bval;
            cnt_ff <= cnt_ff + 61'd1;
            if (pad_ff) begin
               if (!plen_ff) pidx_ff <= 4'd0;
               else if (pidx_ff == 4'd7) pidx_ff <= 4'd8;
               else pidx_ff <= pidx_ff + 4'd1;
               if (pos == 6'd55 || plen_ff) plen_ff <= 1'b1;
            end
            if (pos == 6'd63) begin
               j_ff <= '0;
               {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
               {ap_ff, bp_ff, cp_ff, dp_ff, ep_ff} <=
                  {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
            end
         end
         if (state_ff == ST_IDLE && req.valid && req.kind) begin
            pad_ff  <= 1'b1;
            plen_ff <= 1'b0;
            pidx_ff <= 4'd8;
            bits_ff <= {cnt_ff, 3'b000};
         end
         if (state_ff == ST_RND) begin
            j_ff <= j_ff + 7'd1;
            a_ff <= e_ff; e_ff <= d_ff; d_ff <= rmd_pkg::rotl_f(c_ff, 4'd10);
            c_ff <= b_ff; b_ff <= tl;
            ap_ff <= ep_ff; ep_ff <= dp_ff; dp_ff <= rmd_pkg::rotl_f(cp_ff, 4'd10);
            cp_ff <= bp_ff; bp_ff <= tr;
         end
         if (state_ff == ST_FIN) begin
            h_ff[0] <= h_ff[1] + c_ff + dp_ff;
            h_ff[1] <= h_ff[2] + d_ff + ep_ff;
            h_ff[2] <= h_ff[3] + e_ff + ap_ff;
            h_ff[3] <= h_ff[4] + a_ff + bp_ff;
            h_ff[4] <= h_ff[0] + b_ff + cp_ff;
            oidx_ff <= '0;
         end
         if (state_ff == ST_OUT && rsp.ready) begin
            oidx_ff <= oidx_ff + 3'd1;
            if (oidx_ff == 3'd4) begin
               h_ff   <= '{rmd_pkg::IV0, rmd_pkg::IV1, rmd_pkg::IV2, rmd_pkg::IV3,
                           rmd_pkg::IV4};
               cnt_ff <= '0;
               pad_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp.valid       = (state_ff == ST_OUT);
   assign rsp.digest_word = h_ff[oidx_ff];
   assign rsp.word_index  = oidx_ff;
   assign rsp.last_word   = (oidx_ff == 3'd4);
endmodule

FILE: rtl/rmd_checker.sv
// ----------------------------------------------------------------------------
// rmd_checker
// port-level checks of the ripemd-160 engine
// ----------------------------------------------------------------------------
`include "ripemd160_hash_engine_macros.svh"
module rmd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);
   `RMD_ASSERT_IMP(a_excl, clock, reset, rsp_valid, !req_ready)
   `RMD_ASSERT_IMP(a_idx, clock, reset, rsp_valid, rsp_word_index <= 3'd4)
   `RMD_ASSERT_IMP(a_last, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == 3'd4))
   `RMD_ASSERT_NEXT(a_step, clock, reset, rsp_valid && rsp_ready && !rsp_last_word,
                    rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
endmodule

bind ripemd160_hash_engine rmd_checker u_rmd_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_word_index(rsp.word_index), .rsp_last_word(rsp.last_word)
);

FILE: tb/rmd_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_tb_if
// testbench-side note: the block's channel interfaces come from the rtl
// ----------------------------------------------------------------------------
package rmd_tb_pkg;
   typedef enum logic {KIND_DATA = 1'b0, KIND_FINISH = 1'b1} req_kind_type;
   localparam int WORDS_PER_DIGEST = 5;
endpackage

FILE: tb/rmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_tb_checker
// watches both channels, hashes accepted requests and checks digest words
// ----------------------------------------------------------------------------
module rmd_tb_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic req_kind,
   input  logic [7:0] req_data_byte,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0] rsp_word_index,
   input  logic rsp_last_word,
   output int   fail_count,
   output int   pending_words
);
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   localparam logic [31:0] CH_INIT [5] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                           32'h10325476, 32'hc3d2e1f0};
   localparam int ML_IDX [80] = '{
      0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15, 7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
      3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12, 1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
      4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
   localparam int MR_IDX [80] = '{
      5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12, 6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
      15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13, 8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
      12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
   localparam int ML_ROT [80] = '{
      11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8, 7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
      11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5, 11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
      9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
   localparam int MR_ROT [80] = '{
      8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6, 9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
      9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5, 15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
      8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
   localparam logic [31:0] ML_K [5] = '{32'h0, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc,
                                        32'ha953fd4e};
   localparam logic [31:0] MR_K [5] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3,
                                        32'h7a6d76e9, 32'h0};

   logic [31:0] chain [5];
   logic [31:0] msg_block [16];
   logic [60:0] msg_bytes;
   digest_word_type digest_queue [$];

   function automatic logic [31:0] rol(logic [31:0] x, int n);
      return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
   endfunction

   function automatic logic [31:0] mix(int r, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z);
      case (r)
         0: return x ^ y ^ z;
         1: return (x & y) | (~x & z);
         2: return (x | ~y) ^ z;
         3: return (x & z) | (y & ~z);
         default: return x ^ (y | ~z);
      endcase
   endfunction

   task automatic compress_block();
      logic [31:0] a, b, c, d, e, ap, bp, cp, dp, ep, t;
      int r;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      ap = a; bp = b; cp = c; dp = d; ep = e;
      for (int j = 0; j < 80; j++) begin
         r = j / 16;
         t = rol(a + mix(r, b, c, d) + msg_block[ML_IDX[j]] + ML_K[r], ML_ROT[j]) + e;
         a = e; e = d; d = rol(c, 10); c = b; b = t;
         t = rol(ap + mix(4 - r, bp, cp, dp) + msg_block[MR_IDX[j]] + MR_K[r],
                 MR_ROT[j]) + ep;
         ap = ep; ep = dp; dp = rol(cp, 10); cp = bp; bp = t;
      end
      t = chain[1] + c + dp;
      chain[1] = chain[2] + d + ep;
      chain[2] = chain[3] + e + ap;
      chain[3] = chain[4] + a + bp;
      chain[4] = chain[0] + b + cp;
      chain[0] = t;
   endtask

   task automatic absorb_byte(logic [7:0] value);
      int pos;
      pos = msg_bytes[5:0];
      if (pos % 4 == 0) msg_block[pos / 4] = {24'h0, value};
      else msg_block[pos / 4] |= {24'h0, value} << (8 * (pos % 4));
      msg_bytes = msg_bytes + 61'd1;
      if (pos == 63) compress_block();
   endtask

   task automatic finish_message();
      logic [63:0] bit_len;
      digest_word_type dw;
      bit_len = {msg_bytes, 3'b000};
      absorb_byte(8'h80);
      while (msg_bytes[5:0] != 6'd56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bit_len[8 * i +: 8]);
      for (int i = 0; i < rmd_tb_pkg::WORDS_PER_DIGEST; i++) begin
         dw.word = chain[i];
         dw.index = 3'(i);
         dw.last = (i == rmd_tb_pkg::WORDS_PER_DIGEST - 1);
         digest_queue.push_back(dw);
      end
      chain = CH_INIT;
      msg_bytes = '0;
   endtask

   assign pending_words = digest_queue.size();

   always @(posedge clock) begin
      digest_word_type want;
      if (reset) begin
         chain = CH_INIT;
         msg_bytes = '0;
         for (int i = 0; i < 16; i++) msg_block[i] = '0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_kind == rmd_tb_pkg::KIND_FINISH) finish_message();
            else absorb_byte(req_data_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest word %h", $time, rsp_digest_word);
               fail_count++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_digest_word !== want.word || rsp_word_index !== want.index ||
                   rsp_last_word !== want.last) begin
                  $display("%0t: expected %h/%0d/%b got %h/%0d/%b", $time, want.word,
                           want.index, want.last, rsp_digest_word, rsp_word_index,
                           rsp_last_word);
                  fail_count++;
               end
            end
         end
      end
   end

   initial fail_count = 0;
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// byte-fed ripemd-160: messages of assorted lengths, random stalls, checker
// ----------------------------------------------------------------------------
module testbench;
   logic clock;
   logic reset;
   int   fail_count;
   int   pending_words;
   int   idle_cycles;
   int   sent;
   bit   calm;          // no idling on either side while set
   bit   timed_out;

   rmd_req_if req_ch ();
   rmd_rsp_if rsp_ch ();

   ripemd160_hash_engine dut (.clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch));

   rmd_tb_checker check (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_kind(req_ch.kind), .req_data_byte(req_ch.data_byte),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_digest_word(rsp_ch.digest_word), .rsp_word_index(rsp_ch.word_index),
      .rsp_last_word(rsp_ch.last_word),
      .fail_count(fail_count), .pending_words(pending_words)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.kind = rmd_tb_pkg::KIND_DATA;
      req_ch.data_byte = 0;
      rsp_ch.ready = 0;
      calm = 0;
      timed_out = 0;
   end

   // response side stalls at random, about 37 percent of the time, except in calm stretches
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else rsp_ch.ready <= calm || ($urandom_range(99) >= 37);
   end

   // watchdog: cycles with no request or response accepted
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one request, with a possible idle gap first; returns when ready is high after an edge
   task automatic send_request(rmd_tb_pkg::req_kind_type kind, logic [7:0] value);
      while (!calm && $urandom_range(99) < 37) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.kind <= kind;
      req_ch.data_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_message(int len, int pattern);
      for (int i = 0; i < len; i++) begin
         case (pattern)
            0: send_request(rmd_tb_pkg::KIND_DATA, 8'h00);
            1: send_request(rmd_tb_pkg::KIND_DATA, 8'hff);
            2: send_request(rmd_tb_pkg::KIND_DATA, 8'(i));
            default: send_request(rmd_tb_pkg::KIND_DATA, 8'($urandom_range(255)));
         endcase
      end
      send_request(rmd_tb_pkg::KIND_FINISH, 8'($urandom_range(255)));
   endtask

   initial begin
      int len;
      idle_cycles = 0;
      sent = 0;
      reset = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed: empty messages, finish byte ignored, one byte extremes, three bytes
      send_request(rmd_tb_pkg::KIND_FINISH, 8'h00);
      send_request(rmd_tb_pkg::KIND_FINISH, 8'hff);
      send_message(1, 0);
      send_message(1, 1);
      send_message(3, 2);
      // sender holds off until the digest has drained
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      // random: lengths straddling the one/two padding block border, the block border, and short ones
      while (sent < 130) begin
         case ($urandom_range(5))
            0: len = $urandom_range(55, 57);
            1: len = $urandom_range(63, 65);
            2: len = $urandom_range(0, 5);
            default: len = $urandom_range(0, 40);
         endcase
         calm = ($urandom_range(7) == 0);
         send_message(len, $urandom_range(3));
      end
      // a long calm message crossing a block border
      calm = 1;
      send_message(70, 2);
      calm = 0;
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
